### rtl/core/mi_pkg.sv
// Shared types, constants and helpers for the mass index block.
`default_nettype none
package mi_pkg;
	localparam int WINDOW_MAX_DEF = 32;
	localparam int DIV_W = 72;
	localparam int DIV_CW = 7;
	localparam int BAR_W = 13;

	localparam logic [1:0] CFG_FAST = 2'd0;
	localparam logic [1:0] CFG_SLOW = 2'd1;
	localparam logic [1:0] CFG_WARM = 2'd2;

	localparam logic [9:0] FAST_RESET = 10'd9;
	localparam logic [5:0] SLOW_RESET = 6'd25;
	localparam logic [10:0] WARM_RESET = 11'd8;

	localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
	localparam logic signed [39:0] MAX40 = 40'sh7F_FFFF_FFFF;
	localparam logic signed [39:0] MIN40 = 40'sh80_0000_0000;
	localparam logic signed [39:0] ONE_Q24 = 40'sh00_0100_0000;

	typedef struct packed {
		logic [DIV_W-1:0] dividend;
		logic [47:0] divisor;
		logic [DIV_CW-1:0] count;
	} div_req_t;

	function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
		logic signed [47:0] r;
		if (v > 51'(MAX48))
			r = MAX48;
		else if (v < 51'(MIN48))
			r = MIN48;
		else
			r = v[47:0];
		return r;
	endfunction
endpackage
`default_nettype wire

### rtl/core/mi_bar_if.sv
// Input channel carrying one price bar per request.
`default_nettype none
interface mi_bar_if;
	logic valid;
	logic ready;
	logic [31:0] high_price;
	logic [31:0] low_price;
	modport source(output valid, output high_price, output low_price, input ready);
	modport sink(input valid, input high_price, input low_price, output ready);
endinterface
`default_nettype wire

### rtl/core/mi_mass_if.sv
// Output channel carrying one mass index value per request.
`default_nettype none
interface mi_mass_if;
	logic valid;
	logic ready;
	logic signed [47:0] mass_index;
	modport source(output valid, output mass_index, input ready);
	modport sink(input valid, input mass_index, output ready);
endinterface
`default_nettype wire

### rtl/core/mass_index_stream.sv
// Top level of the streaming mass index: sequencer, EMA state and ratio window.
`default_nettype none
// Mass index over a stream of price bars. One bar is taken at a time; the
// block runs a fixed sequence: up to two EMA updates and one ratio, each
// through a shared bit-serial divider that is started and then collected,
// then the window update with one RAM write and one RAM read. A result
// waits in an output register and the next bar is taken meanwhile; a bar
// that reaches the window while that register is still full holds there
// until it drains. The user must write configuration only while the block
// is idle; the block itself does not enforce this. Ring entries need no
// clearing after reset.
module mass_index_stream
	import mi_pkg::*;
#(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	mi_bar_if.sink           bar,
	mi_mass_if.source        mass,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data
);
	localparam int PW = $clog2(WINDOW_MAX);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ST1  = 4'd1;
	localparam logic [3:0] S_W1   = 4'd2;
	localparam logic [3:0] S_ST2  = 4'd3;
	localparam logic [3:0] S_W2   = 4'd4;
	localparam logic [3:0] S_RAT  = 4'd5;
	localparam logic [3:0] S_W3   = 4'd6;
	localparam logic [3:0] S_WIN  = 4'd7;
	localparam logic [3:0] S_RD   = 4'd8;
	localparam logic [3:0] S_SUB  = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	logic [3:0] state_q;
	logic [9:0] fast_q;
	logic [5:0] slow_q;
	logic [10:0] warm_q;
	logic signed [47:0] ema1_q, ema2_q, sum1_q, sum2_q, total_q, span_q;
	logic signed [39:0] ratio_q;
	logic [PW-1:0] pos_q;
	logic [BAR_W-1:0] bar_q;
	logic neg_q, seed_q;
	logic out_valid_q;
	logic signed [47:0] mass_q;
	div_req_t div_req_q;
	logic div_start_q;
	logic div_done;
	logic [DIV_W-1:0] div_q;
	logic [39:0] ram_rdata;

	// derived configuration
	logic [9:0] fast_eff;
	logic [BAR_W-1:0] fast13, slow13, slow_eff, warm13, warm2, last, kbar;
	logic steady, seed1, seed2, active2, out_free;
	always_comb begin
		fast_eff = (fast_q < 10'd2) ? 10'd2 : fast_q;
		fast13 = BAR_W'(fast_eff);
		slow13 = BAR_W'(slow_q);
		if (slow_q == 6'd0)
			slow_eff = BAR_W'(1);
		else if (slow13 > BAR_W'(WINDOW_MAX))
			slow_eff = BAR_W'(WINDOW_MAX);
		else
			slow_eff = slow13;
		warm13 = BAR_W'(warm_q);
		warm2 = {warm13[BAR_W-2:0], 1'b0};
		last = warm2 + slow_eff - BAR_W'(1);
		steady = bar_q > last;
		kbar = bar_q - warm13;
		seed1 = !steady && (bar_q < fast13);
		active2 = steady || (bar_q >= warm13);
		seed2 = !steady && (kbar < fast13);
		out_free = !out_valid_q || mass.ready;
	end

	// arithmetic around the divider
	logic signed [47:0] nsum1, nsum2, x2, cur_ema;
	logic signed [48:0] diff1, diff2;
	logic signed [49:0] dd1, dd2;
	logic [49:0] abs_dd1, abs_dd2;
	logic [47:0] abs_nsum1, abs_nsum2, abs_ema1, abs_ema2;
	logic signed [50:0] q_s51;
	logic signed [47:0] ema_step, seed_val;
	logic signed [39:0] ratio_div;
	logic [PW-1:0] wpos, npos;
	logic [BAR_W-1:0] wpos1;
	logic signed [47:0] total_add, total_sub;
	always_comb begin
		x2 = ema1_q;
		nsum1 = sat48(51'(sum1_q) + 51'(span_q));
		nsum2 = sat48(51'(sum2_q) + 51'(x2));
		abs_nsum1 = nsum1[47] ? 48'(-nsum1) : 48'(nsum1);
		abs_nsum2 = nsum2[47] ? 48'(-nsum2) : 48'(nsum2);
		diff1 = 49'(span_q) - 49'(ema1_q);
		diff2 = 49'(x2) - 49'(ema2_q);
		dd1 = $signed({diff1, 1'b0});
		dd2 = $signed({diff2, 1'b0});
		abs_dd1 = dd1[49] ? 50'(-dd1) : 50'(dd1);
		abs_dd2 = dd2[49] ? 50'(-dd2) : 50'(dd2);
		abs_ema1 = ema1_q[47] ? 48'(-ema1_q) : 48'(ema1_q);
		abs_ema2 = ema2_q[47] ? 48'(-ema2_q) : 48'(ema2_q);
		cur_ema = (state_q == S_W1) ? ema1_q : ema2_q;
		q_s51 = neg_q ? -$signed({1'b0, div_q[49:0]}) : $signed({1'b0, div_q[49:0]});
		ema_step = sat48(51'(cur_ema) + q_s51);
		seed_val = neg_q ? -$signed(div_q[47:0]) : $signed(div_q[47:0]);
		if (|div_q[DIV_W-1:39])
			ratio_div = neg_q ? MIN40 : MAX40;
		else
			ratio_div = neg_q ? -$signed({1'b0, div_q[38:0]}) : $signed({1'b0, div_q[38:0]});
		wpos = (BAR_W'(pos_q) >= slow_eff) ? '0 : pos_q;
		wpos1 = BAR_W'(wpos) + BAR_W'(1);
		npos = (wpos1 >= slow_eff) ? '0 : wpos1[PW-1:0];
		total_add = sat48(51'(total_q) + 51'(ratio_q));
		total_sub = sat48(51'(total_q) - 51'($signed(ram_rdata)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q <= FAST_RESET;
			slow_q <= SLOW_RESET;
			warm_q <= WARM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FAST: fast_q <= cfg_data[9:0];
				CFG_SLOW: slow_q <= cfg_data[5:0];
				CFG_WARM: warm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ema1_q <= '0;
			ema2_q <= '0;
			sum1_q <= '0;
			sum2_q <= '0;
			total_q <= '0;
			pos_q <= '0;
			bar_q <= '0;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && mass.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (bar.valid) begin
						span_q <= 48'($signed({1'b0, bar.high_price} - {1'b0, bar.low_price})
							* 48'sd256);
						state_q <= S_ST1;
					end
				end
				S_ST1: begin
					if (seed1) begin
						sum1_q <= nsum1;
						if (bar_q == fast13 - BAR_W'(1)) begin
							div_req_q <= '{dividend: {abs_nsum1, 24'b0},
								divisor: 48'(fast_eff), count: DIV_CW'(48)};
							div_start_q <= 1'b1;
							neg_q <= nsum1[47];
							seed_q <= 1'b1;
							state_q <= S_W1;
						end else begin
							state_q <= S_ST2;
						end
					end else begin
						div_req_q <= '{dividend: {abs_dd1, 22'b0},
							divisor: 48'(fast_eff) + 48'd1, count: DIV_CW'(50)};
						div_start_q <= 1'b1;
						neg_q <= dd1[49];
						seed_q <= 1'b0;
						state_q <= S_W1;
					end
				end
				S_W1: begin
					if (div_done) begin
						ema1_q <= seed_q ? seed_val : ema_step;
						state_q <= S_ST2;
					end
				end
				S_ST2: begin
					if (!active2) begin
						state_q <= S_RAT;
					end else if (seed2) begin
						sum2_q <= nsum2;
						if (kbar == fast13 - BAR_W'(1)) begin
							div_req_q <= '{dividend: {abs_nsum2, 24'b0},
								divisor: 48'(fast_eff), count: DIV_CW'(48)};
							div_start_q <= 1'b1;
							neg_q <= nsum2[47];
							seed_q <= 1'b1;
							state_q <= S_W2;
						end else begin
							state_q <= S_RAT;
						end
					end else begin
						div_req_q <= '{dividend: {abs_dd2, 22'b0},
							divisor: 48'(fast_eff) + 48'd1, count: DIV_CW'(50)};
						div_start_q <= 1'b1;
						neg_q <= dd2[49];
						seed_q <= 1'b0;
						state_q <= S_W2;
					end
				end
				S_W2: begin
					if (div_done) begin
						ema2_q <= seed_q ? seed_val : ema_step;
						state_q <= S_RAT;
					end
				end
				S_RAT: begin
					if (bar_q < warm2) begin
						state_q <= S_FIN;
					end else if (ema2_q == 48'sd0) begin
						ratio_q <= ONE_Q24;
						state_q <= S_WIN;
					end else begin
						div_req_q <= '{dividend: {abs_ema1, 24'b0},
							divisor: abs_ema2, count: DIV_CW'(72)};
						div_start_q <= 1'b1;
						neg_q <= ema1_q[47] ^ ema2_q[47];
						state_q <= S_W3;
					end
				end
				S_W3: begin
					if (div_done) begin
						ratio_q <= ratio_div;
						state_q <= S_WIN;
					end
				end
				S_WIN: begin
					// hold until the output register is free
					if (bar_q >= last) begin
						if (out_free) begin
							mass_q <= total_add;
							out_valid_q <= 1'b1;
							total_q <= total_add;
							pos_q <= npos;
							state_q <= S_RD;
						end
					end else begin
						total_q <= total_add;
						pos_q <= npos;
						state_q <= S_FIN;
					end
				end
				S_RD: state_q <= S_SUB;
				S_SUB: begin
					// drop the oldest ratio from the window
					total_q <= total_sub;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (bar_q <= last)
						bar_q <= bar_q + BAR_W'(1);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	mi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.req      (div_req_q),
		.done     (div_done),
		.quotient (div_q)
	);

	mi_ram #(
		.WIDTH (40),
		.DEPTH (WINDOW_MAX)
	) u_ring (
		.clk   (clk),
		.we    (state_q == S_WIN),
		.waddr (wpos),
		.wdata (ratio_q),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	assign bar.ready = (state_q == S_IDLE);
	assign mass.valid = out_valid_q;
	assign mass.mass_index = mass_q;
endmodule
`default_nettype wire

### rtl/core/mi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mi_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/core/mi_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module mi_div
	import mi_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire div_req_t       req,
	output logic                done,
	output logic [DIV_W-1:0]    quotient
);
	logic busy_q;
	logic done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_W-1:0] work_q;
	logic [47:0] rem_q;
	logic [47:0] divisor_q;
	logic [48:0] trial;
	logic [48:0] diff;
	logic ge;

	assign trial = {rem_q, work_q[DIV_W-1]};
	assign ge = trial >= {1'b0, divisor_q};
	assign diff = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= req.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift dividend out at the top, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= req.dividend;
			divisor_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[47:0] : trial[47:0];
			work_q <= {work_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = work_q;
endmodule
`default_nettype wire

### dv/mass_index_checker.sv
// Checker for the mass index block: predicts each bar's result and compares the output stream.
`default_nettype none
module mass_index_checker
	import mi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	mi_bar_if                bar,
	mi_mass_if               mass,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data,
	output int               fail_count,
	output int               pending_count
);
	localparam longint TOP48 = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint BOT48 = -TOP48 - 1;
	localparam longint TOP40 = 64'sh0000_007F_FFFF_FFFF;
	localparam longint BOT40 = -TOP40 - 1;
	localparam longint UNIT_Q24 = 64'sh0100_0000;

	logic [9:0]  fast_reg;
	logic [5:0]  slow_reg;
	logic [10:0] warm_reg;

	longint ema_one, ema_two, seed_one, seed_two, window_sum;
	longint ratio_hist[32];
	int     hist_pos;
	int     bars_seen;

	logic signed [47:0] expected_mass[$];

	assign pending_count = expected_mass.size();

	function automatic longint clamp48(input longint v);
		if (v > TOP48)
			return TOP48;
		if (v < BOT48)
			return BOT48;
		return v;
	endfunction

	function automatic longint smooth(input longint prev, input longint x, input longint den);
		longint d;
		d = x - prev;
		return clamp48(prev + (d * 2) / den);
	endfunction

	// first/second in Q.24, truncated toward zero and clamped to 40 bits; one when second is zero
	function automatic longint ema_quotient(input longint num, input longint den);
		logic [71:0] mag_n;
		logic [71:0] mag_d;
		logic [71:0] q;
		bit          neg;
		if (den == 0)
			return UNIT_Q24;
		neg = (num < 0) != (den < 0);
		mag_n = 72'(num < 0 ? -num : num) << 24;
		mag_d = 72'(den < 0 ? -den : den);
		q = mag_n / mag_d;
		if (q >= (72'd1 << 39))
			return neg ? BOT40 : TOP40;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	task automatic predict_bar(input logic [31:0] hi, input logic [31:0] lo);
		int     fast, slow, warm, last, k;
		longint den, span, q;
		bit     steady;
		fast = (fast_reg < 2) ? 2 : int'(fast_reg);
		slow = (slow_reg < 1) ? 1 : (slow_reg > 32 ? 32 : int'(slow_reg));
		warm = int'(warm_reg);
		last = 2 * warm + slow - 1;
		steady = bars_seen > last;
		den = longint'(fast) + 1;
		span = (longint'(hi) - longint'(lo)) * 256;

		if (!steady && bars_seen < fast) begin
			seed_one = clamp48(seed_one + span);
			if (bars_seen == fast - 1)
				ema_one = seed_one / longint'(fast);
		end else begin
			ema_one = smooth(ema_one, span, den);
		end

		if (steady) begin
			ema_two = smooth(ema_two, ema_one, den);
		end else if (bars_seen >= warm) begin
			k = bars_seen - warm;
			if (k < fast) begin
				seed_two = clamp48(seed_two + ema_one);
				if (k == fast - 1)
					ema_two = seed_two / longint'(fast);
			end else begin
				ema_two = smooth(ema_two, ema_one, den);
			end
		end

		if (bars_seen >= 2 * warm) begin
			q = ema_quotient(ema_one, ema_two);
			if (hist_pos >= slow)
				hist_pos = 0;
			ratio_hist[hist_pos] = q;
			window_sum = clamp48(window_sum + q);
			hist_pos = (hist_pos + 1 >= slow) ? 0 : hist_pos + 1;
			if (bars_seen >= last) begin
				expected_mass.push_back(window_sum[47:0]);
				window_sum = clamp48(window_sum - ratio_hist[hist_pos]);
			end
		end

		if (bars_seen <= last)
			bars_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_reg <= FAST_RESET;
			slow_reg <= SLOW_RESET;
			warm_reg <= WARM_RESET;
			ema_one = 0;
			ema_two = 0;
			seed_one = 0;
			seed_two = 0;
			window_sum = 0;
			hist_pos = 0;
			bars_seen = 0;
			foreach (ratio_hist[i])
				ratio_hist[i] = 0;
			expected_mass.delete();
			fail_count = 0;
		end else begin
			if (mass.valid && mass.ready) begin
				if (expected_mass.size() == 0)
					report_mismatch($sformatf("unexpected mass_index %h", mass.mass_index));
				else if (mass.mass_index !== expected_mass[0])
					report_mismatch($sformatf("mass_index %h, want %h",
						mass.mass_index, expected_mass.pop_front()));
				else
					void'(expected_mass.pop_front());
			end
			if (bar.valid && bar.ready)
				predict_bar(bar.high_price, bar.low_price);
			if (cfg_we) begin
				case (cfg_index)
					CFG_FAST: fast_reg <= cfg_data[9:0];
					CFG_SLOW: slow_reg <= cfg_data[5:0];
					CFG_WARM: warm_reg <= cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

### dv/mass_index_stream_tb.sv
// Top of the mass index testbench: clock, reset, bar stimulus, output stalls and verdict.
`default_nettype none
module mass_index_stream_tb;
	import mi_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int SETTLE = 400;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;
	int          fail_count;
	int          pending_count;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_left;
	int          quiet_cycles;

	mi_bar_if  bar();
	mi_mass_if mass();

	mass_index_stream uut (
		.clk(clk), .arst_n(arst_n), .bar(bar), .mass(mass),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mass_index_checker chk (
		.clk(clk), .arst_n(arst_n), .bar(bar), .mass(mass),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass.ready <= 0;
		end else if (hold_left > 0) begin
			mass.ready <= 0;
			hold_left <= hold_left - 1;
		end else begin
			mass.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((bar.valid && bar.ready) || (mass.valid && mass.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// hold until every expected result is out, then let any bar in flight finish
	task automatic drain();
		while (pending_count != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(input int fast, input int slow, input int warm);
		drain();
		write_reg(CFG_FAST, 11'(fast));
		write_reg(CFG_SLOW, 11'(slow));
		write_reg(CFG_WARM, 11'(warm));
		cfg_we <= 0;
	endtask

	task automatic send_bar(input logic [31:0] hi, input logic [31:0] lo);
		if ($urandom_range(99) < send_idle_pct) begin
			bar.valid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		bar.valid <= 1;
		bar.high_price <= hi;
		bar.low_price <= lo;
		@(posedge clk);
		while (!bar.ready)
			@(posedge clk);
	endtask

	task automatic send_random(input int n);
		logic [31:0] base, hi, lo;
		repeat (n) begin
			base = $urandom;
			case ($urandom_range(5))
				0: begin hi = $urandom; lo = $urandom; end
				1: begin hi = base + $urandom_range(65535); lo = base; end
				2: begin hi = base; lo = base + $urandom_range(65535); end
				3: begin hi = base; lo = base; end
				4: begin hi = base + ($urandom & 32'hFF_FFFF); lo = base; end
				default: begin
					hi = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
					lo = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
				end
			endcase
			send_bar(hi, lo);
		end
		bar.valid <= 0;
		@(posedge clk);
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_FAST;
		cfg_data = 0;
		bar.valid = 0;
		bar.high_price = 0;
		bar.low_price = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		quiet_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// fill the whole ring once so later window changes never read stale entries
		configure(2, 32, 1);
		send_bar(32'hFFFF_FFFF, 32'h0);
		send_bar(32'h0, 32'hFFFF_FFFF);
		send_bar(32'h0, 32'h0);
		send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_bar(32'h8000_0000, 32'h7FFF_FFFF);
		send_bar(32'hAAAA_AAAA, 32'h5555_5555);
		send_bar(32'h5555_5555, 32'hAAAA_AAAA);
		send_bar(32'h0000_0001, 32'h0);
		send_bar(32'h0, 32'h0000_0001);
		send_bar(32'h1234_5678, 32'h1234_5678);
		send_bar(32'h0001_0000, 32'h0);
		send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_bar(32'h7FFF_FFFF, 32'h8000_0000);
		send_bar(32'h0, 32'h0);
		send_bar(32'h0, 32'h0);
		send_bar(32'h0, 32'h0);
		send_random(40);

		configure(1023, 0, 0);
		send_random(150);

		send_idle_pct = 49;
		configure(0, 63, 3);
		send_random(200);

		send_idle_pct = 0;
		recv_stall_pct = 49;
		configure(9, 25, 8);
		send_random(20);
		hold_left = 3000;
		send_random(180);

		send_idle_pct = 30;
		recv_stall_pct = 30;
		configure(1, 5, 2047);
		send_random(30);

		configure(15, 10, 5);
		send_random(250);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		configure(3, 17, 2);
		send_random(150);

		drain();
		if (fail_count == 0 && pending_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
